// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
package spq_pkg;

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int FILL_W  = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       execute;
        logic       apply_insert;
        logic       apply_remove;
        logic [1:0] status;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
    } spq_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller of the sorted priority queue: request sequencing and result handshake.
// Depends on spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.capture      = in_valid && (state_reg == S_IDLE);
        cmd.execute      = (state_reg == S_EXEC) && out_free;
        cmd.apply_insert = 1'b0;
        cmd.apply_remove = 1'b0;
        if (stat.req_remove == REQ_REMOVE)
        begin
            cmd.status       = stat.empty ? ST_EMPTY : ST_REMOVED;
            cmd.apply_remove = cmd.execute && !stat.empty;
        end
        else
        begin
            cmd.status       = stat.full ? ST_FULL : ST_INSERTED;
            cmd.apply_insert = cmd.execute && !stat.full;
        end

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/spq_datapath.sv =====
// Datapath of the sorted priority queue: request register, sorted slot row,
// entry count and result register. Depends on spq_pkg.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_cmd_t                   cmd,
    output spq_stat_t                  stat,
    input  logic                       req_type,
    input  logic signed [VALUE_W-1:0]  item_value,
    input  logic        [PRIO_W-1:0]   item_priority,
    output logic        [1:0]          status,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic        [PRIO_W-1:0]   out_priority,
    output logic        [FILL_W-1:0]   fill_level
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                      req_type_reg;
    logic signed [VALUE_W-1:0] req_value_reg;
    logic        [PRIO_W-1:0]  req_prio_reg;

    logic signed [VALUE_W-1:0] slot_val_reg  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] slot_val_next [QUEUE_DEPTH];
    logic        [PRIO_W-1:0]  slot_pri_reg  [QUEUE_DEPTH];
    logic        [PRIO_W-1:0]  slot_pri_next [QUEUE_DEPTH];
    logic        [QUEUE_DEPTH-1:0] hit;
    logic        [QUEUE_DEPTH-1:0] hit_prev;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic        [1:0]         status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic        [PRIO_W-1:0]  out_prio_reg;
    logic        [FILL_W-1:0]  fill_reg;

    assign stat.req_remove = req_type_reg;
    assign stat.empty      = (cnt_reg == '0);
    assign stat.full       = (cnt_reg == CW'(QUEUE_DEPTH));

    // A slot is at or behind the insertion point when it is empty or holds a
    // priority no higher than the new word; the list is sorted, so this is a
    // run of zeros followed by a run of ones.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit[i] = (CW'(i) >= cnt_reg) || (slot_pri_reg[i] <= req_prio_reg);
        end
        hit_prev[0] = 1'b0;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            hit_prev[i] = hit[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_val_next[i] = slot_val_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
        end
        if (cmd.apply_insert)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (hit[i] && !hit_prev[i])
                begin
                    slot_val_next[i] = req_value_reg;
                    slot_pri_next[i] = req_prio_reg;
                end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (hit_prev[i])
                begin
                    slot_val_next[i] = slot_val_reg[i-1];
                    slot_pri_next[i] = slot_pri_reg[i-1];
                end
            end
        end
        else if (cmd.apply_remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_val_next[i] = slot_val_reg[i+1];
                slot_pri_next[i] = slot_pri_reg[i+1];
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.apply_insert)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.apply_remove)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg  <= req_type;
            req_value_reg <= item_value;
            req_prio_reg  <= item_priority;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_val_reg[i] <= slot_val_next[i];
            slot_pri_reg[i] <= slot_pri_next[i];
        end
        if (cmd.execute)
        begin
            status_reg    <= cmd.status;
            out_value_reg <= cmd.apply_remove ? slot_val_reg[0] : '0;
            out_prio_reg  <= cmd.apply_remove ? slot_pri_reg[0] : '0;
            fill_reg      <= FILL_W'(cnt_next);
        end
    end

    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign fill_level   = fill_reg;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Sorted priority queue, top level: ties the controller to the slot datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Holds up to QUEUE_DEPTH entries sorted by descending priority; a newer entry
// goes ahead of older ones of equal priority. Each request word yields exactly
// one result word. A request is first registered and then applied, the whole
// slot row comparing and shifting in parallel; the result then sits in an
// output register, so a new request is taken while it waits, and the apply
// cycle stalls only while an earlier result is still held. A remove on an
// empty queue reports empty, and an insert on a full queue is dropped with a
// full status. fill_level carries the low five bits of the count.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic signed [VALUE_W-1:0]  item_value,
    input  logic        [PRIO_W-1:0]   item_priority,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic        [1:0]          status,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic        [PRIO_W-1:0]   out_priority,
    output logic        [FILL_W-1:0]   fill_level
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .item_value    (item_value),
        .item_priority (item_priority),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .fill_level    (fill_level)
    );

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core.
module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic        [1:0]          status,
    input logic signed [VALUE_W-1:0]  out_value,
    input logic        [PRIO_W-1:0]   out_priority,
    input logic        [FILL_W-1:0]   fill_level
);

    // A held result word keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(out_value) && $stable(out_priority) && $stable(fill_level))
        else $error("result word changed while stalled");

    // An accepted request word is worked on before the next one is taken.
    a_accept_once: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted word");

    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> fill_level == FILL_W'(QUEUE_DEPTH)
            && out_value == '0 && out_priority == '0)
        else $error("full status with wrong level or payload");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill_level == '0
            && out_value == '0 && out_priority == '0)
        else $error("empty status with nonzero fields");

    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INSERTED |-> out_value == '0 && out_priority == '0)
        else $error("insert result carries a payload");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_value    (out_value),
    .out_priority (out_priority),
    .fill_level   (fill_level)
);
